/* hw/rtl/wrsi_pkg.sv */
`timescale 1ns / 1ps

package wrsi_pkg;

    localparam int PRICE_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int AVG_W    = PRICE_W + FRAC_W;
    localparam int PERIOD_W = 8;
    localparam int RSI_W    = 15;

    // Shared divider geometry: 64-bit dividend, divisor up to G+L (49 bits).
    localparam int DIV_DVD_W       = 64;
    localparam int DIV_DSR_W       = AVG_W + 1;
    localparam int DIV_LONG_STEPS  = DIV_DVD_W;
    // The index quotient never exceeds 25600, so 15 steps cover it.
    localparam int DIV_SHORT_STEPS = DIV_DVD_W - DIV_DSR_W;
    localparam int DIV_CNT_W       = 7;

    localparam logic [RSI_W-1:0]    RSI_FULL     = 15'd25600;
    localparam logic [RSI_W-1:0]    RSI_MID      = 15'd12800;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd14;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP,
        ST_MUL,
        ST_START,
        ST_WAIT,
        ST_RSI_MUL,
        ST_RSI_START,
        ST_RSI_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic short_div;
    } div_req_t;

endpackage

/* hw/rtl/wilder_rsi_calculator.sv */
// Wilder relative strength index over a stream of closing prices.
//
// Input channel: in_valid/in_ready with close_price and quote_valid. A word
// with quote_valid low changes nothing and returns a word with rsi_ready low.
// The first usable price only seeds the previous close; the next `period`
// differences are summed, then averaged (Q16) and smoothed per Wilder.
// Output channel: out_valid/out_ready with rsi_value (RSI * 256) and
// rsi_ready. Every input word yields exactly one output word.
// Config: cfg_wr_en/cfg_wr_data write the period (0 acts as 1); write only
// while the block is idle.
// An ignored or seeding word goes straight to the output, and a warm-up word
// only adds its move to the sums. Once averages are updated, the shared
// bit-serial divider computes each of the two averages and then the index:
// 64 steps for each average and 15 for the index, the index run being
// skipped with a zero loss average. One word is in flight at a time; in_ready
// is high only when idle.
// A finished word sits in the output register, so the next input word is
// taken even while the receiver stalls; a second result then waits until
// the held word is taken.
// Reset clears the period to 14 and drops all averages and history.
`timescale 1ns / 1ps

module wilder_rsi_calculator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [wrsi_pkg::PRICE_W-1:0]   close_price,
    input  logic                           quote_valid,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [wrsi_pkg::RSI_W-1:0]     rsi_value,
    output logic                           rsi_ready,
    input  logic                           cfg_wr_en,
    input  logic [wrsi_pkg::PERIOD_W-1:0]  cfg_wr_data
);
    import wrsi_pkg::*;

    // Sequencer and architectural state
    state_t                state_reg, state_next;
    logic [PERIOD_W-1:0]   period_reg, period_next;
    logic [PRICE_W-1:0]    prev_close_reg, prev_close_next;
    logic                  have_prev_reg, have_prev_next;
    logic [PERIOD_W-1:0]   warm_cnt_reg, warm_cnt_next;
    logic                  warmed_reg, warmed_next;
    // Sums during warm-up, Q16 averages afterwards
    logic [AVG_W-1:0]      avg_gain_reg, avg_gain_next;
    logic [AVG_W-1:0]      avg_loss_reg, avg_loss_next;
    logic                  out_valid_reg, out_valid_next;

    // Working registers of the current word
    logic [PRICE_W-1:0]    gain_reg, gain_next;
    logic [PRICE_W-1:0]    loss_reg, loss_next;
    logic                  first_reg, first_next;
    logic                  side_reg, side_next;
    logic [DIV_DVD_W-1:0]  prod_reg, prod_next;
    logic [DIV_DSR_W-1:0]  den_reg, den_next;
    logic [RSI_W-1:0]      res_value_reg, res_value_next;
    logic                  res_rdy_reg, res_rdy_next;
    logic [RSI_W-1:0]      out_value_reg, out_value_next;
    logic                  out_rdy_reg, out_rdy_next;

    // Derived values
    logic [PERIOD_W-1:0]   n_eff;
    logic [PERIOD_W-1:0]   n_less1;
    logic                  price_up;
    logic [PRICE_W-1:0]    move_mag;
    logic [AVG_W-1:0]      sum_gain;
    logic [AVG_W-1:0]      sum_loss;
    logic [PERIOD_W-1:0]   cnt_inc;
    logic                  warm_done;
    logic [AVG_W-1:0]      avg_sel;
    logic [PRICE_W-1:0]    move_sel;
    logic                  emit_ok;
    logic                  out_load;

    // Divider hookup
    div_req_t              div_req;
    logic [DIV_DVD_W-1:0]  div_dividend;
    logic [DIV_DSR_W-1:0]  div_divisor;
    logic [DIV_DVD_W-1:0]  div_quotient;
    logic                  div_done;

    wrsi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    always_comb
    begin
        // A zero period behaves as one.
        n_eff     = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
        n_less1   = n_eff - PERIOD_W'(1);
        price_up  = close_price > prev_close_reg;
        move_mag  = price_up ? (close_price - prev_close_reg)
                             : (prev_close_reg - close_price);
        sum_gain  = avg_gain_reg + AVG_W'(gain_reg);
        sum_loss  = avg_loss_reg + AVG_W'(loss_reg);
        cnt_inc   = warm_cnt_reg + PERIOD_W'(1);
        warm_done = cnt_inc >= n_eff;
        avg_sel   = side_reg ? avg_loss_reg : avg_gain_reg;
        move_sel  = side_reg ? loss_reg : gain_reg;
        emit_ok   = !out_valid_reg || out_ready;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (quote_valid && have_prev_reg) ? ST_STEP : ST_EMIT;
                end
            end
            ST_STEP:
            begin
                state_next = (warmed_reg || warm_done) ? ST_MUL : ST_EMIT;
            end
            ST_MUL:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    state_next = side_reg ? ST_RSI_MUL : ST_MUL;
                end
            end
            ST_RSI_MUL:
            begin
                state_next = (avg_loss_reg == '0) ? ST_EMIT : ST_RSI_START;
            end
            ST_RSI_START:
            begin
                state_next = ST_RSI_WAIT;
            end
            ST_RSI_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        period_next     = cfg_wr_en ? cfg_wr_data : period_reg;
        prev_close_next = prev_close_reg;
        have_prev_next  = have_prev_reg;
        warm_cnt_next   = warm_cnt_reg;
        warmed_next     = warmed_reg;
        avg_gain_next   = avg_gain_reg;
        avg_loss_next   = avg_loss_reg;
        gain_next       = gain_reg;
        loss_next       = loss_reg;
        first_next      = first_reg;
        side_next       = side_reg;
        prod_next       = prod_reg;
        den_next        = den_reg;
        res_value_next  = res_value_reg;
        res_rdy_next    = res_rdy_reg;
        div_req         = '0;
        div_dividend    = prod_reg;
        div_divisor     = den_reg;
        out_load        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_value_next = '0;
                    res_rdy_next   = 1'b0;
                    if (quote_valid)
                    begin
                        prev_close_next = close_price;
                        have_prev_next  = 1'b1;
                        // Equal price counts as a zero loss.
                        gain_next       = price_up ? move_mag : '0;
                        loss_next       = price_up ? '0 : move_mag;
                    end
                end
            end
            ST_STEP:
            begin
                side_next  = 1'b0;
                first_next = !warmed_reg;
                if (!warmed_reg)
                begin
                    avg_gain_next = sum_gain;
                    avg_loss_next = sum_loss;
                    warm_cnt_next = cnt_inc;
                    if (warm_done)
                    begin
                        warmed_next = 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next = DIV_DVD_W'(avg_sel) * DIV_DVD_W'(n_less1);
            end
            ST_START:
            begin
                div_req.start = 1'b1;
                div_divisor   = DIV_DSR_W'(n_eff);
                // First average divides the plain sum, later ones smooth.
                if (first_reg)
                begin
                    div_dividend = {avg_sel, {FRAC_W{1'b0}}};
                end
                else
                begin
                    div_dividend = prod_reg + DIV_DVD_W'({move_sel, {FRAC_W{1'b0}}});
                end
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    if (side_reg)
                    begin
                        avg_loss_next = div_quotient[AVG_W-1:0];
                    end
                    else
                    begin
                        avg_gain_next = div_quotient[AVG_W-1:0];
                    end
                    side_next = 1'b1;
                end
            end
            ST_RSI_MUL:
            begin
                if (avg_loss_reg == '0)
                begin
                    res_value_next = (avg_gain_reg != '0) ? RSI_FULL : RSI_MID;
                    res_rdy_next   = 1'b1;
                end
                else
                begin
                    prod_next = DIV_DVD_W'(avg_gain_reg) * DIV_DVD_W'(RSI_FULL);
                    den_next  = DIV_DSR_W'(avg_gain_reg) + DIV_DSR_W'(avg_loss_reg);
                end
            end
            ST_RSI_START:
            begin
                div_req.start     = 1'b1;
                div_req.short_div = 1'b1;
            end
            ST_RSI_WAIT:
            begin
                if (div_done)
                begin
                    res_value_next = div_quotient[RSI_W-1:0];
                    res_rdy_next   = 1'b1;
                end
            end
            ST_EMIT:
            begin
                out_load = emit_ok;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase

        // Hold the output word until taken; load a new one behind it.
        out_valid_next = out_load || (out_valid_reg && !out_ready);
        out_value_next = out_load ? res_value_reg : out_value_reg;
        out_rdy_next   = out_load ? res_rdy_reg : out_rdy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            period_reg     <= PERIOD_RESET;
            prev_close_reg <= '0;
            have_prev_reg  <= 1'b0;
            warm_cnt_reg   <= '0;
            warmed_reg     <= 1'b0;
            avg_gain_reg   <= '0;
            avg_loss_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            period_reg     <= period_next;
            prev_close_reg <= prev_close_next;
            have_prev_reg  <= have_prev_next;
            warm_cnt_reg   <= warm_cnt_next;
            warmed_reg     <= warmed_next;
            avg_gain_reg   <= avg_gain_next;
            avg_loss_reg   <= avg_loss_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gain_reg      <= gain_next;
        loss_reg      <= loss_next;
        first_reg     <= first_next;
        side_reg      <= side_next;
        prod_reg      <= prod_next;
        den_reg       <= den_next;
        res_value_reg <= res_value_next;
        res_rdy_reg   <= res_rdy_next;
        out_value_reg <= out_value_next;
        out_rdy_reg   <= out_rdy_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign rsi_value = out_value_reg;
    assign rsi_ready = out_rdy_reg;

endmodule

/* hw/rtl/wrsi_div.sv */
`timescale 1ns / 1ps

module wrsi_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  wrsi_pkg::div_req_t               req,
    input  logic [wrsi_pkg::DIV_DVD_W-1:0]   dividend,
    input  logic [wrsi_pkg::DIV_DSR_W-1:0]   divisor,
    output logic [wrsi_pkg::DIV_DVD_W-1:0]   quotient,
    output logic                             done
);
    import wrsi_pkg::*;

    logic [DIV_DVD_W-1:0] dvd_reg, dvd_next;
    logic [DIV_DSR_W-1:0] rem_reg, rem_next;
    logic [DIV_DSR_W-1:0] dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;

    logic [DIV_DSR_W:0]   rem_shift;
    logic [DIV_DSR_W+1:0] trial;
    logic                 qbit;

    // One restoring step: shift in the next dividend bit, try the subtract.
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[DIV_DVD_W-1]};
        trial     = {1'b0, rem_shift} - {2'b00, dsr_reg};
        qbit      = ~trial[DIV_DSR_W+1];
    end

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            dsr_next = divisor;
            if (req.short_div)
            begin
                // Skip the leading steps whose quotient bits are known zero.
                rem_next = dividend[DIV_DVD_W-1:DIV_SHORT_STEPS];
                dvd_next = {dividend[DIV_SHORT_STEPS-1:0], {DIV_DSR_W{1'b0}}};
                cnt_next = DIV_CNT_W'(DIV_SHORT_STEPS);
            end
            else
            begin
                rem_next = '0;
                dvd_next = dividend;
                cnt_next = DIV_CNT_W'(DIV_LONG_STEPS);
            end
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = qbit ? trial[DIV_DSR_W-1:0] : rem_shift[DIV_DSR_W-1:0];
            dvd_next  = {dvd_reg[DIV_DVD_W-2:0], qbit};
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

/* hw/rtl/wrsi_chk.sv */
`timescale 1ns / 1ps

module wrsi_chk (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [wrsi_pkg::RSI_W-1:0]     rsi_value,
    input  logic                           rsi_ready
);
    import wrsi_pkg::*;

    // Hold a stalled output word.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(rsi_value) && $stable(rsi_ready)))
        else $error("output word changed while stalled");

    a_rsi_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rsi_value <= RSI_FULL))
        else $error("rsi_value above 100");

    a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !rsi_ready) |-> (rsi_value == '0))
        else $error("rsi_value nonzero without rsi_ready");

    // One word in flight: drop ready after an accept.
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a word is in flight");

endmodule

bind wilder_rsi_calculator wrsi_chk u_wrsi_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rsi_value (rsi_value),
    .rsi_ready (rsi_ready)
);
